// ===== sv/lip_pkg.sv =====
package lip_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int T_BITS = 32;

  localparam logic [T_BITS-1:0] T_MAX = {1'b0, {(T_BITS-1){1'b1}}};
  localparam logic [T_BITS-1:0] T_MIN = {1'b1, {(T_BITS-1){1'b0}}};

  // register stages ahead of the quotient steps: diffs, products, sums, abs, range check
  localparam int PRE_STAGES = 5;
  localparam int LATENCY    = PRE_STAGES + T_BITS + 1;

  typedef enum logic [1:0] {
    REL_INTERSECT = 2'd0,
    REL_PARALLEL  = 2'd1,
    REL_COLLINEAR = 2'd2
  } relation_e;

  typedef struct packed {
    relation_e rel;
    logic      neg;
    logic      ovf;
  } ctl_t;

endpackage

// ===== sv/lip_div_step.sv =====
module lip_div_step #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 34,
  parameter int SHIFT = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  lip_pkg::ctl_t             ctl_i,
  input  logic [NUM_W-1:0]          rem_i,
  input  logic [DEN_W-1:0]          den_i,
  input  logic [lip_pkg::T_BITS-1:0] q_i,
  output logic                      valid_o,
  output lip_pkg::ctl_t             ctl_o,
  output logic [NUM_W-1:0]          rem_o,
  output logic [DEN_W-1:0]          den_o,
  output logic [lip_pkg::T_BITS-1:0] q_o
);

  localparam int CMP_W = (NUM_W > DEN_W + SHIFT) ? NUM_W : DEN_W + SHIFT;

  logic [CMP_W-1:0]           rem_ext;
  logic [CMP_W-1:0]           den_sh;
  logic [CMP_W-1:0]           diff;
  logic                       ge;
  logic                       valid_q;
  lip_pkg::ctl_t              ctl_q;
  logic [NUM_W-1:0]           rem_d, rem_q;
  logic [DEN_W-1:0]           den_q;
  logic [lip_pkg::T_BITS-1:0] q_d, q_q;

  always_comb begin
    rem_ext = CMP_W'(rem_i);
    den_sh  = CMP_W'(den_i) << SHIFT;
    ge      = rem_ext >= den_sh;
    diff    = rem_ext - den_sh;
    rem_d   = ge ? NUM_W'(diff) : rem_i;
    q_d     = {q_i[lip_pkg::T_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_i;
    rem_q <= rem_d;
    den_q <= den_i;
    q_q   <= q_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign q_o     = q_q;

endmodule

// ===== sv/line_intersection_param_unit.sv =====
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------------------------
// command  | in        | start, busy            | first_*_x/y_i, second_*_x/y_i (A, B, C, D)
// result   | out       | done_o (one-cycle)     | relation_o, param_t_o, t_saturated_o
//
// One line pair is taken every cycle; busy stays low.
// Each result passes through 5 front stages, one stage per quotient bit
// of the 32-step restoring divider, and one output stage.
// Reset clears every valid bit in the pipeline; payload registers are not reset.
// Results are shown for one cycle only and cannot be held.
module line_intersection_param_unit #(
  parameter int COORD_BITS  = lip_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = lip_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  first_start_x_i,
  input  logic signed [COORD_BITS-1:0]  first_start_y_i,
  input  logic signed [COORD_BITS-1:0]  first_end_x_i,
  input  logic signed [COORD_BITS-1:0]  first_end_y_i,
  input  logic signed [COORD_BITS-1:0]  second_start_x_i,
  input  logic signed [COORD_BITS-1:0]  second_start_y_i,
  input  logic signed [COORD_BITS-1:0]  second_end_x_i,
  input  logic signed [COORD_BITS-1:0]  second_end_y_i,
  output logic                          done_o,
  output logic [1:0]                    relation_o,
  output logic signed [lip_pkg::T_BITS-1:0] param_t_o,
  output logic                          t_saturated_o
);

  localparam int TB    = lip_pkg::T_BITS;
  localparam int DIF_W = COORD_BITS + 1;
  localparam int W     = 2 * COORD_BITS + 2;
  localparam int DVD_W = W + T_FRAC_BITS;
  localparam int OVF_W = W + TB;

  // stage 1: normal and differences
  logic                    v1_q;
  logic signed [DIF_W-1:0] nx_q, ny_q, bax_q, bay_q, acx_q, acy_q;
  // stage 2: products
  logic                    v2_q;
  logic signed [W-1:0]     p0_q, p1_q, p2_q, p3_q;
  // stage 3: dot products
  logic                    v3_q;
  logic signed [W-1:0]     denom_q, num_q;
  // stage 4: magnitudes and relation
  logic                    v4_q;
  logic [DVD_W-1:0]        x4_q;
  logic [W-1:0]            dmag4_q;
  lip_pkg::ctl_t           ctl4_d, ctl4_q;
  logic [W-1:0]            nmag, dmag;
  logic                    dzero, nzero;
  // stage 5: quotient range check
  logic                    v5_q;
  logic [DVD_W-1:0]        x5_q;
  logic [W-1:0]            dmag5_q;
  lip_pkg::ctl_t           ctl5_d, ctl5_q;
  // quotient steps
  logic                    valid_c [0:TB];
  lip_pkg::ctl_t           ctl_c   [0:TB];
  logic [DVD_W-1:0]        rem_c   [0:TB];
  logic [W-1:0]            den_c   [0:TB];
  logic [TB-1:0]           q_c     [0:TB];
  // output stage
  logic                    done_q;
  lip_pkg::relation_e      rel_q;
  logic [TB-1:0]           t_d, t_q;
  logic                    sat_d, sat_q;
  logic                    big;
  lip_pkg::ctl_t           ctl_f;
  logic [TB-1:0]           q_f;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= DIF_W'(second_end_y_i) - DIF_W'(second_start_y_i);
    ny_q  <= DIF_W'(second_start_x_i) - DIF_W'(second_end_x_i);
    bax_q <= DIF_W'(first_end_x_i) - DIF_W'(first_start_x_i);
    bay_q <= DIF_W'(first_end_y_i) - DIF_W'(first_start_y_i);
    acx_q <= DIF_W'(first_start_x_i) - DIF_W'(second_start_x_i);
    acy_q <= DIF_W'(first_start_y_i) - DIF_W'(second_start_y_i);
  end

  always_ff @(posedge clk_i) begin
    p0_q <= W'(nx_q * bax_q);
    p1_q <= W'(ny_q * bay_q);
    p2_q <= W'(nx_q * acx_q);
    p3_q <= W'(ny_q * acy_q);
  end

  always_ff @(posedge clk_i) begin
    denom_q <= p0_q + p1_q;
    num_q   <= p2_q + p3_q;
  end

  always_comb begin
    dzero = (denom_q == '0);
    nzero = (num_q == '0);
    nmag  = num_q[W-1] ? W'(-num_q) : W'(num_q);
    dmag  = denom_q[W-1] ? W'(-denom_q) : W'(denom_q);
    ctl4_d.ovf = 1'b0;
    ctl4_d.neg = (num_q[W-1] == denom_q[W-1]) && !nzero;
    if (!dzero) begin
      ctl4_d.rel = lip_pkg::REL_INTERSECT;
    end else if (nzero) begin
      ctl4_d.rel = lip_pkg::REL_COLLINEAR;
    end else begin
      ctl4_d.rel = lip_pkg::REL_PARALLEL;
    end
  end

  always_ff @(posedge clk_i) begin
    x4_q    <= {nmag, {T_FRAC_BITS{1'b0}}};
    dmag4_q <= dmag;
    ctl4_q  <= ctl4_d;
  end

  always_comb begin
    ctl5_d     = ctl4_q;
    ctl5_d.ovf = OVF_W'(x4_q) >= (OVF_W'(dmag4_q) << TB);
  end

  always_ff @(posedge clk_i) begin
    x5_q    <= x4_q;
    dmag5_q <= dmag4_q;
    ctl5_q  <= ctl5_d;
  end

  assign valid_c[0] = v5_q;
  assign ctl_c[0]   = ctl5_q;
  assign rem_c[0]   = x5_q;
  assign den_c[0]   = dmag5_q;
  assign q_c[0]     = '0;

  for (genvar k = 0; k < TB; k++) begin : g_step
    lip_div_step #(
      .NUM_W (DVD_W),
      .DEN_W (W),
      .SHIFT (TB - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .ctl_i   (ctl_c[k]),
      .rem_i   (rem_c[k]),
      .den_i   (den_c[k]),
      .q_i     (q_c[k]),
      .valid_o (valid_c[k+1]),
      .ctl_o   (ctl_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .den_o   (den_c[k+1]),
      .q_o     (q_c[k+1])
    );
  end

  always_comb begin
    ctl_f = ctl_c[TB];
    q_f   = q_c[TB];
    big   = ctl_f.neg ? (q_f > lip_pkg::T_MIN) : (q_f > lip_pkg::T_MAX);
    if (ctl_f.rel != lip_pkg::REL_INTERSECT) begin
      t_d   = '0;
      sat_d = 1'b0;
    end else if (ctl_f.ovf || big) begin
      t_d   = ctl_f.neg ? lip_pkg::T_MIN : lip_pkg::T_MAX;
      sat_d = 1'b1;
    end else begin
      t_d   = ctl_f.neg ? (~q_f + TB'(1)) : q_f;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c[TB];
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q <= ctl_f.rel;
    t_q   <= t_d;
    sat_q <= sat_d;
  end

  assign done_o        = done_q;
  assign relation_o    = rel_q;
  assign param_t_o     = t_q;
  assign t_saturated_o = sat_q;

endmodule

// ===== sv/lip_chk.sv =====
module lip_chk #(
  parameter int COORD_BITS = lip_pkg::COORD_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [COORD_BITS-1:0]       second_start_x_i,
  input logic [COORD_BITS-1:0]       second_start_y_i,
  input logic [COORD_BITS-1:0]       second_end_x_i,
  input logic [COORD_BITS-1:0]       second_end_y_i,
  input logic                        done_o,
  input logic [1:0]                  relation_o,
  input logic [lip_pkg::T_BITS-1:0]  param_t_o,
  input logic                        t_saturated_o
);

  localparam int LAT = lip_pkg::LATENCY;

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_done_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a matching command");

  a_no_t_when_parallel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && relation_o != lip_pkg::REL_INTERSECT) |-> (param_t_o == '0 && !t_saturated_o))
    else $error("nonzero t on parallel lines");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && t_saturated_o) |->
      (param_t_o == lip_pkg::T_MAX || param_t_o == lip_pkg::T_MIN))
    else $error("saturated t not at an extreme");

  a_point_second_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && second_start_x_i == second_end_x_i &&
     second_start_y_i == second_end_y_i) |->
      ##LAT (!done_o || relation_o == lip_pkg::REL_COLLINEAR))
    else $error("degenerate second line not collinear");

endmodule

bind line_intersection_param_unit lip_chk #(
  .COORD_BITS (COORD_BITS)
) u_lip_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .second_start_x_i (second_start_x_i),
  .second_start_y_i (second_start_y_i),
  .second_end_x_i   (second_end_x_i),
  .second_end_y_i   (second_end_y_i),
  .done_o           (done_o),
  .relation_o       (relation_o),
  .param_t_o        (param_t_o),
  .t_saturated_o    (t_saturated_o)
);
